// File: design/complementary_tilt_filter_assert.svh
// assertion macros for the complementary tilt filter
`ifndef COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

`ifndef SYNTH
// consequent must hold in the same cycle as the antecedent
`define CTF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctf same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define CTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctf next-cycle check failed");
`else
`define CTF_ASSERT_NOW(label, ante, cons)
`define CTF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/ctf_pkg.sv
// shared types, constants and helper functions of the complementary tilt filter
package ctf_pkg;

    // cordic datapath widths
    localparam int XY_W   = 36;
    localparam int Z_W    = 34;
    localparam int TILT_W = 18;
    localparam int ATAN_W = 30;
    localparam int ATAN_N = 24;

    // fuse datapath widths
    localparam int MUL_A_W = 20;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 180 degrees in 2^-23 degree units
    localparam logic signed [Z_W-1:0] DEG180 = 34'sd1509949440;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // configuration register indexes
    localparam logic [0:0] CFG_GYRO_GAIN    = 1'b0;
    localparam logic [0:0] CFG_BLEND_WEIGHT = 1'b1;

    localparam logic [23:0] GYRO_GAIN_RST    = 24'd21475;
    localparam logic [16:0] BLEND_WEIGHT_RST = 17'd64225;

    // atan(2^-i) in 2^-23 degree units
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:  val = 30'd377487360;
            5'd1:  val = 30'd222843801;
            5'd2:  val = 30'd117744544;
            5'd3:  val = 30'd59768969;
            5'd4:  val = 30'd30000467;
            5'd5:  val = 30'd15014858;
            5'd6:  val = 30'd7509261;
            5'd7:  val = 30'd3754860;
            5'd8:  val = 30'd1877459;
            5'd9:  val = 30'd938733;
            5'd10: val = 30'd469367;
            5'd11: val = 30'd234683;
            5'd12: val = 30'd117342;
            5'd13: val = 30'd58671;
            5'd14: val = 30'd29335;
            5'd15: val = 30'd14668;
            5'd16: val = 30'd7334;
            5'd17: val = 30'd3667;
            5'd18: val = 30'd1833;
            5'd19: val = 30'd917;
            5'd20: val = 30'd458;
            5'd21: val = 30'd229;
            5'd22: val = 30'd115;
            5'd23: val = 30'd57;
            default: val = '0;
        endcase
        return val;
    endfunction

    // clamp to the 16 bit angle range
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: design/complementary_tilt_filter.sv
// complementary roll/pitch filter with a shared cordic and a shared multiplier
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  accel_x, accel_y, accel_z, rate_roll, rate_pitch
//  output    out        out_valid/out_stall  roll_out, pitch_out
//  config    in         cfg_we               cfg_index, cfg_data
//
//  a request runs, per axis (roll then pitch), the cordic iteration loop and then the
//  fuse steps; the first request after reset loads the tilt instead of fusing.
//  a zero accel vector skips the iterations.
//  in_stall is high whenever a request is in work; the result sits in an output
//  register, so the next request may be accepted while out_stall holds the last one.
//  rst_n clears the angles, the started flag and loads the register defaults.
module complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [18:0] rate_roll,
    input  logic signed [18:0] rate_pitch,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_out,
    output logic signed [15:0] pitch_out,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import ctf_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CINIT = 4'd1;   // load cordic vector for current axis
    localparam logic [3:0] S_CITER = 4'd2;   // one micro-rotation per cycle
    localparam logic [3:0] S_TILT  = 4'd3;   // round angle accumulator
    localparam logic [3:0] S_LOAD  = 4'd4;   // first sample: angle = tilt
    localparam logic [3:0] S_MR    = 4'd5;   // rate * gain
    localparam logic [3:0] S_PROP  = 4'd6;   // angle + rounded increment
    localparam logic [3:0] S_MW    = 4'd7;   // prop * weight
    localparam logic [3:0] S_MT    = 4'd8;   // tilt * (1 - weight)
    localparam logic [3:0] S_SUM   = 4'd9;   // round, saturate, store angle
    localparam logic [3:0] S_DONE  = 4'd10;  // hand result to output register

    // control state
    logic [3:0]        state_reg, state_next;
    logic              axis_reg, axis_next;       // 0 roll, 1 pitch
    logic [STEP_W-1:0] iter_reg, iter_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [23:0]       gyro_gain_reg, gyro_gain_next;
    logic [16:0]       blend_weight_reg, blend_weight_next;
    logic signed [15:0] roll_angle_reg, roll_angle_next;
    logic signed [15:0] pitch_angle_reg, pitch_angle_next;

    // payload and datapath registers
    logic signed [15:0]        ax_reg, ax_next;
    logic signed [15:0]        ay_reg, ay_next;
    logic signed [15:0]        az_reg, az_next;
    logic signed [18:0]        rr_reg, rr_next;
    logic signed [18:0]        rp_reg, rp_next;
    logic signed [XY_W-1:0]    x_reg, x_next;
    logic signed [XY_W-1:0]    y_reg, y_next;
    logic signed [Z_W-1:0]     z_reg, z_next;
    logic signed [TILT_W-1:0]  tilt_reg, tilt_next;
    logic signed [MUL_A_W-1:0] prop_reg, prop_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic signed [15:0]        roll_out_reg, roll_out_next;
    logic signed [15:0]        pitch_out_reg, pitch_out_next;

    logic                      accept;
    logic                      out_free;
    logic signed [15:0]        num;
    logic signed [XY_W-1:0]    num_ext;
    logic signed [XY_W-1:0]    den_ext;
    logic signed [XY_W-1:0]    x_sh;
    logic signed [XY_W-1:0]    y_sh;
    logic signed [Z_W-1:0]     atan_ext;
    logic signed [Z_W-1:0]     z_round;
    logic [16:0]               w_eff;
    logic signed [15:0]        angle_cur;
    logic signed [18:0]        rate_cur;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  inc_round;
    logic signed [PROD_W-1:0]  blend_sum;
    logic signed [15:0]        new_angle;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign roll_out  = roll_out_reg;
    assign pitch_out = pitch_out_reg;

    // weight above one acts as one
    assign w_eff = (blend_weight_reg > ONE_Q16) ? ONE_Q16 : blend_weight_reg;

    // per-axis operand selection
    assign num       = axis_reg ? ay_reg : ax_reg;
    assign angle_cur = axis_reg ? pitch_angle_reg : roll_angle_reg;
    assign rate_cur  = axis_reg ? rp_reg : rr_reg;
    assign num_ext   = {{(XY_W-32){num[15]}}, num, 16'h0000};
    assign den_ext   = {{(XY_W-32){az_reg[15]}}, az_reg, 16'h0000};

    // shared cordic shifter and angle table
    assign x_sh     = x_reg >>> iter_reg;
    assign y_sh     = y_reg >>> iter_reg;
    assign atan_ext = $signed({{(Z_W-ATAN_W){1'b0}}, atan_lut(5'(iter_reg))});
    assign z_round  = z_reg + 34'sd32768;

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MR:
            begin
                mul_a = {rate_cur[18], rate_cur};
                mul_b = $signed({1'b0, gyro_gain_reg});
            end
            S_MW:
            begin
                mul_a = prop_reg;
                mul_b = $signed({8'h00, w_eff});
            end
            S_MT:
            begin
                mul_a = {{(MUL_A_W-TILT_W){tilt_reg[TILT_W-1]}}, tilt_reg};
                mul_b = $signed({8'h00, 17'(ONE_Q16 - w_eff)});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign inc_round = prod_reg + 45'sd8388608;
    assign blend_sum = acc_reg + prod_reg + 45'sd32768;
    assign new_angle = (state_reg == S_LOAD)
                       ? sat16({{(32-TILT_W){tilt_reg[TILT_W-1]}}, tilt_reg})
                       : sat16({{3{blend_sum[PROD_W-1]}}, blend_sum[PROD_W-1:16]});

    always_comb
    begin
        state_next        = state_reg;
        axis_next         = axis_reg;
        iter_next         = iter_reg;
        started_next      = started_reg;
        out_valid_next    = out_valid_reg;
        gyro_gain_next    = gyro_gain_reg;
        blend_weight_next = blend_weight_reg;
        roll_angle_next   = roll_angle_reg;
        pitch_angle_next  = pitch_angle_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        az_next           = az_reg;
        rr_next           = rr_reg;
        rp_next           = rp_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        tilt_next         = tilt_reg;
        prop_next         = prop_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        roll_out_next     = roll_out_reg;
        pitch_out_next    = pitch_out_reg;

        // register writes
        if (cfg_we)
        begin
            if (cfg_index == CFG_GYRO_GAIN)
            begin
                gyro_gain_next = cfg_data;
            end
            else if (cfg_index == CFG_BLEND_WEIGHT)
            begin
                blend_weight_next = cfg_data[16:0];
            end
        end

        // output register drains when taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ax_next    = accel_x;
                    ay_next    = accel_y;
                    az_next    = accel_z;
                    rr_next    = rate_roll;
                    rp_next    = rate_pitch;
                    axis_next  = 1'b0;
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                iter_next = '0;
                if (num == 16'sd0 && az_reg == 16'sd0)
                begin
                    // zero vector: tilt is zero, skip the rotations
                    z_next     = '0;
                    state_next = S_TILT;
                end
                else
                begin
                    if (az_reg < 16'sd0)
                    begin
                        // left half plane: pre-rotate by 180 degrees
                        x_next = -den_ext;
                        y_next = -num_ext;
                        z_next = (num >= 16'sd0) ? DEG180 : -DEG180;
                    end
                    else
                    begin
                        x_next = den_ext;
                        y_next = num_ext;
                        z_next = '0;
                    end
                    state_next = S_CITER;
                end
            end
            S_CITER:
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_ext;
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_ext;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_STEP)
                begin
                    state_next = S_TILT;
                end
            end
            S_TILT:
            begin
                tilt_next  = z_round[Z_W-1:16];
                state_next = started_reg ? S_MR : S_LOAD;
            end
            S_MR:
            begin
                prod_next  = mul_p;
                state_next = S_PROP;
            end
            S_PROP:
            begin
                // rounded increment fits in 20 bits, prop too
                prop_next  = {{(MUL_A_W-16){angle_cur[15]}}, angle_cur} + inc_round[43:24];
                state_next = S_MW;
            end
            S_MW:
            begin
                prod_next  = mul_p;
                state_next = S_MT;
            end
            S_MT:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_LOAD, S_SUM:
            begin
                if (axis_reg)
                begin
                    pitch_angle_next = new_angle;
                    axis_next        = 1'b0;
                    state_next       = S_DONE;
                end
                else
                begin
                    roll_angle_next = new_angle;
                    axis_next       = 1'b1;
                    state_next      = S_CINIT;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    roll_out_next  = roll_angle_reg;
                    pitch_out_next = pitch_angle_reg;
                    out_valid_next = 1'b1;
                    started_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= 1'b0;
            iter_reg         <= '0;
            started_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            gyro_gain_reg    <= GYRO_GAIN_RST;
            blend_weight_reg <= BLEND_WEIGHT_RST;
            roll_angle_reg   <= '0;
            pitch_angle_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            axis_reg         <= axis_next;
            iter_reg         <= iter_next;
            started_reg      <= started_next;
            out_valid_reg    <= out_valid_next;
            gyro_gain_reg    <= gyro_gain_next;
            blend_weight_reg <= blend_weight_next;
            roll_angle_reg   <= roll_angle_next;
            pitch_angle_reg  <= pitch_angle_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        rr_reg        <= rr_next;
        rp_reg        <= rp_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        tilt_reg      <= tilt_next;
        prop_reg      <= prop_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        roll_out_reg  <= roll_out_next;
        pitch_out_reg <= pitch_out_next;
    end

    // an accepted request always starts with the roll cordic setup
    `include "complementary_tilt_filter_assert.svh"
    `CTF_ASSERT_NEXT(a_accept_starts, accept, state_reg == S_CINIT && !axis_reg)
    // started flag only rises together with the first result
    `CTF_ASSERT_NOW(a_started_result, $rose(started_reg), out_valid_reg)
    // back in idle the sequencer points at the roll axis again
    `CTF_ASSERT_NOW(a_idle_axis, state_reg == S_IDLE, !axis_reg)

endmodule

// File: sim/complementary_tilt_filter_tb.sv
// self-checking testbench for the complementary tilt filter: predicted angles vs dut results
module complementary_tilt_filter_tb;
    import ctf_pkg::*;

    // run length guard, far above the slowest legal run (~600 requests)
    localparam int CYCLE_LIMIT = 600000;
    // long receiver hold-off, in cycles
    localparam int HOLD_LEN = 400;
    // final wait before the check for results that never arrived
    localparam int DRAIN_CYCLES = 60;
    localparam longint HALF_TURN_Q23 = 64'sd1509949440;
    localparam longint UNITY_Q16 = 64'sd65536;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } angle_pair_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [18:0] rate_roll;
    logic signed [18:0] rate_pitch;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] roll_out;
    logic signed [15:0] pitch_out;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [23:0]        cfg_data;

    // model copy of the filter state and its registers
    logic [23:0]        gain_reg;
    logic [16:0]        weight_reg;
    logic signed [15:0] roll_state;
    logic signed [15:0] pitch_state;
    logic               seen_sample;

    // angles still owed by the dut, oldest first
    angle_pair_t pending_angles[$];

    int  err_count = 0;
    int  cycle_count = 0;
    bit  idle_en = 1'b1;
    bit  stall_en = 1'b1;
    bit  hold_req = 1'b0;
    logic hold_off = 1'b0;
    int  stall_left = 0;
    bit  stall_now;
    int  hold_count;

    complementary_tilt_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .rate_roll  (rate_roll),
        .rate_pitch (rate_pitch),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .roll_out   (roll_out),
        .pitch_out  (pitch_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // atan(2^-i) in 2^-23 degree units
    function automatic longint atan_step(input int idx);
        longint v;
        case (idx)
            0:  v = 377487360;
            1:  v = 222843801;
            2:  v = 117744544;
            3:  v = 59768969;
            4:  v = 30000467;
            5:  v = 15014858;
            6:  v = 7509261;
            7:  v = 3754860;
            8:  v = 1877459;
            9:  v = 938733;
            10: v = 469367;
            11: v = 234683;
            12: v = 117342;
            13: v = 58671;
            14: v = 29335;
            15: v = 14668;
            16: v = 7334;
            17: v = 3667;
            18: v = 1833;
            19: v = 917;
            20: v = 458;
            21: v = 229;
            22: v = 115;
            23: v = 57;
            default: v = 0;
        endcase
        return v;
    endfunction

    // vectoring cordic, atan2(num, den) in 1/128 degree
    function automatic longint accel_tilt(input longint num, input longint den);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint res;
        int     i;
        x = den * 65536;
        y = num * 65536;
        z = 0;
        if (num == 0 && den == 0)
        begin
            // zero vector gives level
            res = 0;
        end
        else
        begin
            // left half plane: turn by half a revolution first
            if (x < 0)
            begin
                z = (y >= 0) ? HALF_TURN_Q23 : -HALF_TURN_Q23;
                x = -x;
                y = -y;
            end
            for (i = 0; i < 16; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_step(i);
                end
                else
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_step(i);
                end
                x = nx;
            end
            res = (z + 32768) >>> 16;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp_angle(input longint v);
        logic signed [15:0] r;
        if (v > 32767)
            r = 16'sh7fff;
        else if (v < -32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // gyro propagation then weighted mix with the accel tilt
    function automatic logic signed [15:0] blend_axis(input longint angle, input longint rate,
                                                      input longint acc);
        longint g;
        longint w;
        longint prop;
        g = gain_reg;
        w = weight_reg;
        // oversized weight acts as unity
        if (w > UNITY_Q16)
            w = UNITY_Q16;
        prop = angle + ((rate * g + 64'sd8388608) >>> 24);
        return clamp_angle((prop * w + acc * (UNITY_Q16 - w) + 64'sd32768) >>> 16);
    endfunction

    task automatic reset_model();
        gain_reg    = GYRO_GAIN_RST;
        weight_reg  = BLEND_WEIGHT_RST;
        roll_state  = '0;
        pitch_state = '0;
        seen_sample = 1'b0;
    endtask

    // advance the model by one sample and queue the angles it owes
    task automatic track_attitude(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                  input logic signed [15:0] az, input logic signed [18:0] rr,
                                  input logic signed [18:0] rp);
        longint t_roll;
        longint t_pitch;
        angle_pair_t owed;
        t_roll  = accel_tilt(ax, az);
        t_pitch = accel_tilt(ay, az);
        if (!seen_sample)
        begin
            // first sample after reset loads the tilt directly
            roll_state  = clamp_angle(t_roll);
            pitch_state = clamp_angle(t_pitch);
            seen_sample = 1'b1;
        end
        else
        begin
            roll_state  = blend_axis(roll_state, rr, t_roll);
            pitch_state = blend_axis(pitch_state, rp, t_pitch);
        end
        owed.roll  = roll_state;
        owed.pitch = pitch_state;
        pending_angles.push_back(owed);
    endtask

    // offer one request, wait for acceptance, then predict it
    task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az, input logic signed [18:0] rr,
                               input logic signed [18:0] rp);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        accel_x    <= ax;
        accel_y    <= ay;
        accel_z    <= az;
        rate_roll  <= rr;
        rate_pitch <= rp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_attitude(ax, ay, az, rr, rp);
    endtask

    function automatic logic signed [15:0] rand_axis();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 512) - 256);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh7fff;
                    1: v = 16'sh8000;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            // near one g on either side, with noise
            default: v = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                             + $urandom_range(0, 2048) - 1024);
        endcase
        return v;
    endfunction

    function automatic logic signed [18:0] rand_rate();
        logic signed [18:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = 19'($urandom);
            2: v = 19'($urandom_range(0, 8192) - 4096);
            default: v = $urandom_range(0, 1) ? 19'sh3ffff : 19'sh40000;
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_sample(rand_axis(), rand_axis(), rand_axis(), rand_rate(), rand_rate());
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // register write, only called while the filter is idle
    task automatic write_reg(input logic [0:0] idx, input logic [23:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_GYRO_GAIN:    gain_reg   = data;
            CFG_BLEND_WEIGHT: weight_reg = data[16:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [23:0] gain, input logic [23:0] weight);
        wait_idle();
        write_reg(CFG_GYRO_GAIN, gain);
        write_reg(CFG_BLEND_WEIGHT, weight);
    endtask

    // first sample, axis extremes and the tilt corner cases
    task automatic test_directed_cases();
        // first sample after reset loads tilt
        send_sample(16'sd1000, -16'sd500, 16'sd16384, 19'sd0, 19'sd0);
        // zero vector
        send_sample(16'sd0, 16'sd0, 16'sd0, 19'sd1000, -19'sd1000);
        // negative denominator with zero numerator gives plus half turn
        send_sample(16'sd0, 16'sd0, -16'sd16384, 19'sd100, -19'sd100);
        // negative denominator with negative numerator
        send_sample(-16'sd1, -16'sd1, -16'sd1, 19'sd0, 19'sd0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 19'sh3ffff, 19'sh3ffff);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 19'sh40000, 19'sh40000);
        // zero and near-zero denominator
        send_sample(16'sh7fff, 16'sh8000, 16'sd0, 19'sd0, 19'sd0);
        send_sample(16'sh8000, 16'sh7fff, 16'sd1, -19'sd1, 19'sd1);
        // zero weight: pure accel tilt
        set_config(24'd21475, 24'd0);
        send_sample(16'sd3000, -16'sd7000, 16'sd9000, 19'sh3ffff, 19'sh40000);
        send_sample(-16'sd3000, 16'sd7000, -16'sd9000, 19'sd0, 19'sd0);
        // largest gain with unity weight drives the angles into saturation
        set_config(24'hffffff, 24'd65536);
        repeat (3)
            send_sample(16'sd0, 16'sd0, 16'sd16384, 19'sh3ffff, 19'sh3ffff);
        repeat (3)
            send_sample(16'sd0, 16'sd0, 16'sd16384, 19'sh40000, 19'sh40000);
        // oversized weight acts as unity, upper data bits dropped
        set_config(24'd40000, 24'hffffff);
        send_sample(16'sd100, 16'sd200, 16'sd300, 19'sd50000, -19'sd50000);
        send_sample(16'sh8000, 16'sh7fff, -16'sd5, -19'sd70000, 19'sd70000);
        set_config(GYRO_GAIN_RST, BLEND_WEIGHT_RST);
    endtask

    // random traffic under a sweep of register settings
    task automatic test_config_sweep();
        set_config(24'd0, 24'd0);
        send_random(40);
        set_config(24'hffffff, 24'd65536);
        send_random(40);
        set_config(24'($urandom), 24'($urandom_range(0, 131071)));
        send_random(40);
        set_config(GYRO_GAIN_RST, BLEND_WEIGHT_RST);
        send_random(40);
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_random(24);
        wait_idle();
    endtask

    // bulk random traffic, mostly near the default tuning
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
                set_config(24'($urandom_range(0, 200000)), 24'($urandom_range(60000, 65536)));
            else if (phase == 2)
                set_config(24'($urandom), 24'($urandom_range(0, 131071)));
            send_random(100);
        end
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate();
        set_config(GYRO_GAIN_RST, BLEND_WEIGHT_RST);
        idle_en  = 1'b0;
        stall_en = 1'b0;
        send_random(60);
        wait_idle();
    endtask

    // receiver stall: random bursts plus the long hold-off
    always @(negedge clk)
    begin
        stall_now = 1'b0;
        if (stall_left > 0)
        begin
            stall_now = 1'b1;
            stall_left--;
        end
        else if (stall_en && $urandom_range(0, 5) == 0)
        begin
            stall_now  = 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        out_stall <= stall_now || hold_off;
    end

    // long hold-off, counted here
    always
    begin
        wait (hold_req);
        @(negedge clk);
        hold_off <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_LEN)
        begin
            @(negedge clk);
            hold_count++;
        end
        hold_off <= 1'b0;
        hold_req = 1'b0;
    end

    // result checker: each accepted result against the oldest owed angles
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t unexpected result roll %0d pitch %0d", $time, roll_out, pitch_out);
                err_count++;
            end
            else
            begin
                if (roll_out !== pending_angles[0].roll)
                begin
                    $display("%0t roll_out mismatch expected %0d actual %0d", $time,
                             pending_angles[0].roll, roll_out);
                    err_count++;
                end
                if (pitch_out !== pending_angles[0].pitch)
                begin
                    $display("%0t pitch_out mismatch expected %0d actual %0d", $time,
                             pending_angles[0].pitch, pitch_out);
                    err_count++;
                end
                void'(pending_angles.pop_front());
            end
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d results outstanding", $time, pending_angles.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        accel_x    = '0;
        accel_y    = '0;
        accel_z    = '0;
        rate_roll  = '0;
        rate_pitch = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_GYRO_GAIN;
        cfg_data   = '0;
        reset_model();
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_config_sweep();
        test_backpressure();
        test_random_traffic();
        test_full_rate();

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_angles.size() != 0)
        begin
            $display("%0t %0d results never arrived", $time, pending_angles.size());
            err_count++;
        end
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
